### sv/dams_pkg.sv
package dams_pkg;

    localparam int DIGITS      = 256;
    localparam int IDX_W       = $clog2(DIGITS);
    localparam int CNT_W       = IDX_W + 1;
    localparam int DIGIT_W     = 4;
    localparam int FACTOR_W    = 10;
    localparam int CARRY_W     = 10;
    localparam int VALUE_W     = 14;
    localparam int SUM_W       = 12;

    // divide by ten as (v * 52429) >> 19, exact for every v below 2**14
    localparam int RECIP_MUL   = 52429;
    localparam int RECIP_SHIFT = 19;
    localparam int PROD_W      = 30;

    localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

    localparam int SUM_BOUND = (9 * DIGITS > 4095) ? 4095 : 9 * DIGITS;

    typedef struct packed {
        logic             start;
        logic             rd;
        logic [IDX_W-1:0] addr;
        logic             load_out;
    } t_cmd;

    typedef struct packed {
        logic last;
        logic out_free;
    } t_status;

endpackage

### sv/dams_ctrl.sv
module dams_ctrl
    import dams_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RUN  = 2'd1;
    localparam logic [1:0] ST_FIN  = 2'd2;

    logic [1:0]       r_state;
    logic [1:0]       n_state;
    logic [CNT_W-1:0] r_cnt;
    logic [CNT_W-1:0] n_cnt;
    logic             w_issue;

    assign o_in_ready = (r_state == ST_IDLE);
    assign w_issue    = (r_state == ST_RUN) && (r_cnt < CNT_W'(DIGITS));

    always_comb begin
        o_cmd          = '0;
        o_cmd.start    = o_in_ready && i_in_valid;
        o_cmd.rd       = w_issue;
        o_cmd.addr     = r_cnt[IDX_W-1:0];
        o_cmd.load_out = (r_state == ST_FIN) && i_status.out_free;
    end

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        unique case (r_state)
            ST_IDLE: begin
                n_cnt = '0;
                if (i_in_valid) begin
                    n_state = ST_RUN;
                end
            end
            ST_RUN: begin
                if (w_issue) begin
                    n_cnt = r_cnt + CNT_W'(1);
                end
                if (i_status.last) begin
                    n_state = ST_FIN;
                end
            end
            ST_FIN: begin
                // hold the finished result until the output slot frees up
                if (i_status.out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

endmodule

### sv/dams_datapath.sv
module dams_datapath
    import dams_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_cmd                i_cmd,
    input  logic [FACTOR_W-1:0] i_factor,
    input  logic                i_restart,
    input  logic                i_out_ready,
    output t_status             o_status,
    output logic                o_out_valid,
    output logic [SUM_W-1:0]    o_out_sum,
    output logic                o_out_ovf
);

    logic [DIGIT_W-1:0]  r_mem [DIGITS];

    logic [FACTOR_W-1:0] r_factor;
    logic                r_restart;
    logic                r_fresh;
    logic                r_ovf;

    // stage 1: registered read data
    logic                r_v1;
    logic [IDX_W-1:0]    r_a1;
    logic [DIGIT_W-1:0]  r_rdata;
    logic [DIGIT_W-1:0]  w_digit_in;

    // stage 2: digit times factor
    logic                r_v2;
    logic [IDX_W-1:0]    r_a2;
    logic [VALUE_W-1:0]  r_p;

    logic [CARRY_W-1:0]  r_carry;
    logic [SUM_W-1:0]    r_sum;

    logic [VALUE_W-1:0]  w_value;
    logic [PROD_W-1:0]   w_prod;
    logic [CARRY_W-1:0]  n_carry;
    logic [VALUE_W-1:0]  w_rem;
    logic [DIGIT_W-1:0]  w_digit;
    logic [SUM_W:0]      w_sum_ext;
    logic [SUM_W-1:0]    n_sum;
    logic                w_last;

    logic                r_out_valid;
    logic [SUM_W-1:0]    r_out_sum;
    logic                r_out_ovf;

    // a restarted pass ignores the store and reads the value one
    assign w_digit_in = r_restart ? ((r_a1 == '0) ? DIGIT_W'(1) : '0) : r_rdata;

    assign w_value   = r_p + VALUE_W'(r_carry);
    assign w_prod    = PROD_W'(w_value) * PROD_W'(RECIP_MUL);
    assign n_carry   = w_prod[RECIP_SHIFT +: CARRY_W];
    assign w_rem     = w_value - VALUE_W'(n_carry) * VALUE_W'(10);
    assign w_digit   = w_rem[DIGIT_W-1:0];
    assign w_sum_ext = {1'b0, r_sum} + (SUM_W+1)'(w_digit);
    assign n_sum     = w_sum_ext[SUM_W] ? SUM_MAX : w_sum_ext[SUM_W-1:0];
    assign w_last    = r_v2 && (r_a2 == IDX_W'(DIGITS - 1));

    assign o_status.last     = w_last;
    assign o_status.out_free = !r_out_valid || i_out_ready;

    assign o_out_valid = r_out_valid;
    assign o_out_sum   = r_out_sum;
    assign o_out_ovf   = r_out_ovf;

    always_ff @(posedge i_clk) begin
        if (r_v2) begin
            r_mem[r_a2] <= w_digit;
        end
        if (i_cmd.rd) begin
            r_rdata <= r_mem[i_cmd.addr];
        end
    end

    always_ff @(posedge i_clk) begin
        r_a1 <= i_cmd.addr;
        r_a2 <= r_a1;
        r_p  <= VALUE_W'(w_digit_in) * VALUE_W'(r_factor);
        if (i_cmd.start) begin
            r_factor  <= i_factor;
            r_restart <= i_restart || r_fresh;
            r_carry   <= '0;
            r_sum     <= '0;
        end else if (r_v2) begin
            r_carry <= n_carry;
            r_sum   <= n_sum;
        end
        if (i_cmd.load_out) begin
            r_out_sum <= r_sum;
            r_out_ovf <= r_ovf;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_fresh     <= 1'b1;
            r_ovf       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_v1 <= i_cmd.rd;
            r_v2 <= r_v1;
            if (i_cmd.start) begin
                r_fresh <= 1'b0;
            end
            if (w_last && (n_carry != '0)) begin
                r_ovf <= 1'b1;
            end
            if (i_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

endmodule

### sv/decimal_accumulator_multiply_digit_sum.sv
// Decimal accumulator: holds a DIGITS-digit decimal number, multiplies it by
// the factor of each input transfer and returns the digit sum.
//
// Input stream: tdata carries the factor, tuser the restart flag. Restart
// reloads the number with one before the multiply. Output stream: tdata
// carries the digit sum (saturates at 4095), tuser the sticky overflow flag.
//
// One input transfer gives one output transfer. The multiply walks the
// digit memory once, one digit per cycle, through a three-stage loop (read,
// digit times factor, carry and divide by ten). Input ready is high only
// between items, so a new item is accepted only once the last one has
// finished its pass.
//
// Reset clears the overflow flag and makes the next item start from one.
// A stalled output holds its result; the next item may be accepted and
// computed meanwhile, and then waits at the end of its pass for the slot.
module decimal_accumulator_multiply_digit_sum
    import dams_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [15:0] i_s_tdata,   // [9:0] factor, [15:10] zero
    input  logic [0:0]  i_s_tuser,   // [0] restart
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [15:0] o_m_tdata,   // [11:0] digit_sum, [15:12] zero
    output logic [0:0]  o_m_tuser    // [0] overflow
);

    t_cmd             w_cmd;
    t_status          w_status;
    logic [SUM_W-1:0] w_sum;
    logic             w_ovf;

    dams_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_tvalid),
        .o_in_ready (o_s_tready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    dams_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .i_factor    (i_s_tdata[FACTOR_W-1:0]),
        .i_restart   (i_s_tuser[0]),
        .i_out_ready (i_m_tready),
        .o_status    (w_status),
        .o_out_valid (o_m_tvalid),
        .o_out_sum   (w_sum),
        .o_out_ovf   (w_ovf)
    );

    assign o_m_tdata = {(16 - SUM_W)'(0), w_sum};
    assign o_m_tuser = w_ovf;

endmodule

### sv/dams_checker.sv
module dams_checker
    import dams_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_s_tvalid,
    input logic        o_s_tready,
    input logic [15:0] i_s_tdata,
    input logic [0:0]  i_s_tuser,
    input logic        o_m_tvalid,
    input logic        i_m_tready,
    input logic [15:0] o_m_tdata,
    input logic [0:0]  o_m_tuser
);

    logic r_ovf_sent;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovf_sent <= 1'b0;
        end else if (o_m_tvalid && i_m_tready && o_m_tuser[0]) begin
            r_ovf_sent <= 1'b1;
        end
    end

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata)
            && $stable(o_m_tuser))
        else $error("stalled output changed");

    // an item in flight blocks the input side
    a_busy_after_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready |=> !o_s_tready)
        else $error("input ready right after a transfer");

    // overflow never falls once reported
    a_ovf_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && r_ovf_sent |-> o_m_tuser[0])
        else $error("overflow flag dropped");

    a_sum_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> o_m_tdata <= 16'(SUM_BOUND))
        else $error("digit sum out of range");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid && o_s_tready)
        else $error("not idle after reset");

endmodule

bind decimal_accumulator_multiply_digit_sum dams_checker u_dams_checker (.*);
